/* design/qnm_pkg.sv */
// ----------------------------------------------------------------------------
// qnm_pkg
// Shared types and constants of the quantized neuron: number formats,
// command and mode codes, the queued item and the quantizing helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package qnm_pkg;

    // Fixed-point format
    localparam int FRAC_BITS     = 8;
    localparam int INT_BITS      = 8;
    localparam int MAG_W         = INT_BITS + FRAC_BITS;
    localparam int VAL_W         = 17;
    localparam int LG_TABLE_SIZE = 5;
    localparam int TABLE_SIZE    = 1 << LG_TABLE_SIZE;
    localparam int TVAL_W        = 9;
    localparam int SCALE_W       = 16;

    // Command codes
    localparam logic [1:0] CMD_MAC = 2'd0;
    localparam logic [1:0] CMD_FIN = 2'd1;
    localparam logic [1:0] CMD_TBL = 2'd2;

    // Activation modes
    localparam logic [1:0] MODE_RELU = 2'd0;
    localparam logic [1:0] MODE_SIG  = 2'd1;

    // Register indexes
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_LOW   = 2'd1;
    localparam logic [1:0] REG_HIGH  = 2'd2;
    localparam logic [1:0] REG_SCALE = 2'd3;

    // One queued item
    typedef struct packed {
        logic [1:0]                   kind;
        logic signed [VAL_W-1:0]      act;
        logic signed [VAL_W-1:0]      wb;
        logic [LG_TABLE_SIZE-1:0]     tidx;
        logic [TVAL_W-1:0]            tval;
    } item_t;

    // Truncated, wrapped magnitude of a 17-bit signed value
    function automatic logic [MAG_W-1:0] mag17(input logic signed [VAL_W-1:0] v);
        logic [VAL_W-1:0] m;
        m = v[VAL_W-1] ? (~v + 1'b1) : v;
        return m[MAG_W-1:0];
    endfunction

    // Quantize an 18-bit signed sum: wrap magnitude, keep sign
    function automatic logic signed [VAL_W-1:0] quant18(input logic signed [VAL_W:0] v);
        logic [VAL_W:0]     m;
        logic [VAL_W-1:0]   mw;
        m  = v[VAL_W] ? (~v + 1'b1) : v;
        mw = {1'b0, m[MAG_W-1:0]};
        return v[VAL_W] ? (~mw + 1'b1) : mw;
    endfunction

endpackage

`default_nettype wire

/* design/qnm_front.sv */
// ----------------------------------------------------------------------------
// qnm_front
// Input side: takes stream transfers, drops unused commands and holds
// accepted items in a two-entry queue for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module qnm_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire qnm_pkg::item_t in_item,
    output logic               q_valid,
    output qnm_pkg::item_t     q_item,
    input  wire logic          q_pop
);

    qnm_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;
    logic           keep;

    assign in_ready = (count_reg != 2'd2);
    assign keep     = (in_item.kind != 2'd3);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the accepted item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* design/qnm_back.sv */
// ----------------------------------------------------------------------------
// qnm_back
// Execution side: accumulates quantized products, finishes a neuron with
// bias and activation, and owns the sigmoid table and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qnm_back
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   q_valid,
    input  wire qnm_pkg::item_t                         q_item,
    output logic                                        q_pop,
    input  wire logic [1:0]                             act_mode,
    input  wire logic signed [qnm_pkg::VAL_W-1:0]       low_bound,
    input  wire logic signed [qnm_pkg::VAL_W-1:0]       high_bound,
    input  wire logic [qnm_pkg::SCALE_W-1:0]            index_scale,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [qnm_pkg::VAL_W-1:0]            out_value
);

    localparam int VW  = qnm_pkg::VAL_W;
    localparam int MW  = qnm_pkg::MAG_W;
    localparam int FB  = qnm_pkg::FRAC_BITS;
    localparam int LG  = qnm_pkg::LG_TABLE_SIZE;
    localparam int TW  = qnm_pkg::TVAL_W;
    localparam int PW  = VW + qnm_pkg::SCALE_W;
    localparam int SW  = 2 * TW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_MIX  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic signed [VW-1:0]    acc_reg;
    logic [2*MW-1:0]         prod_reg;
    logic                    neg_reg;
    logic signed [VW-1:0]    s_reg;
    logic [PW-1:0]           scaled_reg;
    logic [TW-1:0]           tab_a_reg, tab_b_reg;
    logic [FB-1:0]           d_reg;
    logic signed [VW-1:0]    res_reg;
    logic                    out_valid_reg;
    logic signed [VW-1:0]    out_value_reg;
    logic [TW-1:0]           table_mem [qnm_pkg::TABLE_SIZE];

    logic [MW-1:0]           ma, mw, pmag;
    logic                    na, nw;
    logic signed [VW-1:0]    prod_val;
    logic [VW-1:0]           diff;
    logic [MW-1:0]           t_val;
    logic [MW-FB-1:0]        idx_raw;
    logic [LG-1:0]           idx, nxt;
    logic [SW-1:0]           mix_sum;
    logic                    emit_ok;

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign emit_ok   = !out_valid_reg || out_ready;

    // Operand magnitudes and signs of a term, the product value, and the table index and interpolation terms
    always_comb
    begin
        ma       = qnm_pkg::mag17(q_item.act);
        mw       = qnm_pkg::mag17(q_item.wb);
        na       = q_item.act[VW-1] && (ma != '0);
        nw       = q_item.wb[VW-1] && (mw != '0);
        pmag     = prod_reg[FB +: MW];
        prod_val = neg_reg ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
        diff     = VW'(s_reg - low_bound);
        t_val    = scaled_reg[FB +: MW];
        idx_raw  = t_val[MW-1:FB];
        idx      = (idx_raw > (MW-FB)'(qnm_pkg::TABLE_SIZE - 1)) ? '1 : idx_raw[LG-1:0];
        nxt      = (idx == '1) ? idx : idx + 1'b1;
        mix_sum  = SW'(tab_a_reg) * SW'({1'b1, {FB{1'b0}}} - {1'b0, d_reg})
                 + SW'(tab_b_reg) * SW'(d_reg);
    end

    // Sequence control
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.kind)
                        qnm_pkg::CMD_MAC: state_next = ST_MAC;
                        qnm_pkg::CMD_FIN: state_next = ST_FIN;
                        default:          state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MAC:  state_next = ST_IDLE;
            ST_FIN:
            begin
                if (act_mode == qnm_pkg::MODE_SIG && s_reg >= low_bound
                    && s_reg < high_bound)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_RD:   state_next = ST_MIX;
            ST_MIX:  state_next = ST_EMIT;
            ST_EMIT: state_next = emit_ok ? ST_IDLE : ST_EMIT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MAC)
            begin
                acc_reg <= qnm_pkg::quant18({prod_val[VW-1], prod_val}
                                            + {acc_reg[VW-1], acc_reg});
            end
            else if (q_pop && q_item.kind == qnm_pkg::CMD_FIN)
            begin
                acc_reg <= '0;
            end
            if (state_reg == ST_EMIT && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            prod_reg <= ma * mw;
            neg_reg  <= na ^ nw;
            s_reg    <= qnm_pkg::quant18({acc_reg[VW-1], acc_reg}
                                         + {q_item.wb[VW-1], q_item.wb});
        end
        if (state_reg == ST_FIN)
        begin
            scaled_reg <= diff * index_scale;
            if (act_mode == qnm_pkg::MODE_RELU)
            begin
                res_reg <= s_reg[VW-1] ? '0 : s_reg;
            end
            else if (act_mode == qnm_pkg::MODE_SIG)
            begin
                res_reg <= (s_reg < low_bound) ? '0 : VW'(1 << FB);
            end
            else
            begin
                res_reg <= s_reg;
            end
        end
        if (state_reg == ST_RD)
        begin
            tab_a_reg <= table_mem[idx];
            tab_b_reg <= table_mem[nxt];
            d_reg     <= t_val[FB-1:0];
        end
        if (state_reg == ST_MIX)
        begin
            res_reg <= VW'(mix_sum >> FB);
        end
        if (state_reg == ST_EMIT && emit_ok)
        begin
            out_value_reg <= res_reg;
        end
    end

    // Sigmoid table writes
    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.kind == qnm_pkg::CMD_TBL)
        begin
            table_mem[q_item.tidx] <= q_item.tval;
        end
    end

endmodule

`default_nettype wire

/* design/quantized_neuron_mac_activation.sv */
// ----------------------------------------------------------------------------
// quantized_neuron_mac_activation
// One fully connected neuron in sign-magnitude fixed point with a
// configurable ReLU / table sigmoid activation.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------
//   s_t*     | in        | s_tvalid / s_tready     | s_tuser, s_tdata
//   m_t*     | out       | m_tvalid / m_tready     | m_tdata
//   APB      | in        | psel, penable, pwrite   | paddr, pwdata, prdata
//
// In the execution side a MAC term is a multiply, then an accumulate; a table
// write is done on pop; a finish adds the bias and applies the activation,
// for a sigmoid sum inside the bounds by a scale multiply, two-port table
// read and interpolation. A two-entry queue decouples input from execution.
// Reset clears the accumulator and registers; the table is undefined until
// written. A stalled output holds the execution side at its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_neuron_mac_activation
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // command
    input  wire logic [47:0] s_tdata,   // activation_in, weight_or_bias,
                                        // table_index, table_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // neuron_out
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int VW = qnm_pkg::VAL_W;

    logic [1:0]                    mode_reg;
    logic signed [VW-1:0]          low_reg;
    logic signed [VW-1:0]          high_reg;
    logic [qnm_pkg::SCALE_W-1:0]   scale_reg;
    qnm_pkg::item_t                in_item;
    qnm_pkg::item_t                q_item;
    logic                          q_valid, q_pop;
    logic signed [VW-1:0]          out_value;
    logic                          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Unpack the input transfer
    always_comb
    begin
        in_item.kind = s_tuser;
        in_item.act  = s_tdata[16:0];
        in_item.wb   = s_tdata[33:17];
        in_item.tidx = s_tdata[38:34];
        in_item.tval = s_tdata[47:39];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= qnm_pkg::MODE_RELU;
            low_reg   <= -VW'(2048);
            high_reg  <= VW'(2048);
            scale_reg <= 16'd496;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                qnm_pkg::REG_MODE:  mode_reg  <= pwdata[1:0];
                qnm_pkg::REG_LOW:   low_reg   <= pwdata[VW-1:0];
                qnm_pkg::REG_HIGH:  high_reg  <= pwdata[VW-1:0];
                qnm_pkg::REG_SCALE: scale_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (paddr[3:2])
            qnm_pkg::REG_MODE:  prdata = {30'd0, mode_reg};
            qnm_pkg::REG_LOW:   prdata = {{(32-VW){low_reg[VW-1]}}, low_reg};
            qnm_pkg::REG_HIGH:  prdata = {{(32-VW){high_reg[VW-1]}}, high_reg};
            qnm_pkg::REG_SCALE: prdata = {16'd0, scale_reg};
            default:            prdata = 32'd0;
        endcase
    end

    qnm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    qnm_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .act_mode    (mode_reg),
        .low_bound   (low_reg),
        .high_bound  (high_reg),
        .index_scale (scale_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_value   (out_value)
    );

    assign m_tdata = {7'd0, out_value};

endmodule

`default_nettype wire

/* tb/sv/tb_quantized_neuron_mac_activation.sv */
// ----------------------------------------------------------------------------
// tb_quantized_neuron_mac_activation
// Self-checking bench for the quantized neuron. A queue-fed driver sends
// MAC, finish, table and unused items in random bursts. A monitor checks
// each neuron output against a predictor of the wrapped sign-magnitude
// arithmetic and the table sigmoid. Phases step through activation modes
// and sigmoid bounds, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quantized_neuron_mac_activation;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 20;
    localparam int  RANDOM_ITEMS = 190;
    localparam int  NUM_PHASES   = 9;
    localparam int  TSIZE        = qnm_pkg::TABLE_SIZE;
    localparam int  FB           = qnm_pkg::FRAC_BITS;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] MODE_NONE  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [47:0] data;
    } neuron_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;   // command
    logic [47:0] s_tdata;   // activation_in, weight_or_bias, table_index, table_value
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // neuron_out
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    quantized_neuron_mac_activation uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state and register copies
    longint      acc_fx;
    longint      sig_tbl [TSIZE];
    logic [1:0]  mode_cfg;
    longint      low_cfg;
    longint      high_cfg;
    longint      scale_cfg;

    neuron_item_t  pending_items[$];
    logic [16:0]   neuron_expected[$];

    int  err_cnt;
    int  accepted_cnt;
    int  burst_left;
    int  gap_left;
    int  hold_cnt;
    bit  hold_done;
    int  stall_mode;
    int  cycle_cnt;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Wrap a truncated magnitude, then reapply the sign
    function automatic longint wrap_fx(bit neg, longint mag);
        longint m;
        m = mag & 64'hFFFF;
        return neg ? -m : m;
    endfunction

    function automatic longint quant_fx(longint v);
        return wrap_fx(v < 0, (v < 0) ? -v : v);
    endfunction

    function automatic longint abs_fx(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint sext17(logic [16:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint sigmoid_fx(longint s);
        longint t;
        longint idx;
        longint nxt;
        longint d;
        if (s < low_cfg)
            return 0;
        if (s >= high_cfg)
            return 256;
        t   = (((s - low_cfg) * scale_cfg) >>> FB) & 64'hFFFF;
        idx = t >>> FB;
        d   = t & 255;
        if (idx > TSIZE - 1)
            idx = TSIZE - 1;
        nxt = (idx + 1 > TSIZE - 1) ? TSIZE - 1 : idx + 1;
        return ((sig_tbl[idx] * (256 - d) + sig_tbl[nxt] * d) >>> FB) & 64'hFFFF;
    endfunction

    // Advance the neuron model by one accepted transfer
    task automatic predict_neuron(logic [1:0] cmd, logic [47:0] data);
        longint a;
        longint w;
        longint qa;
        longint qw;
        longint s;
        longint r;
        longint prod;
        a = sext17(data[16:0]);
        w = sext17(data[33:17]);
        case (cmd)
            qnm_pkg::CMD_MAC:
            begin
                qa   = quant_fx(a);
                qw   = quant_fx(w);
                prod = wrap_fx((qa < 0) != (qw < 0), (abs_fx(qa) * abs_fx(qw)) >>> FB);
                acc_fx = quant_fx(acc_fx + prod);
            end
            qnm_pkg::CMD_TBL:
                sig_tbl[data[38:34]] = data[47:39];
            qnm_pkg::CMD_FIN:
            begin
                s = quant_fx(acc_fx + w);
                acc_fx = 0;
                if (mode_cfg == qnm_pkg::MODE_RELU)
                    r = (s < 0) ? 0 : s;
                else if (mode_cfg == qnm_pkg::MODE_SIG)
                    r = sigmoid_fx(s);
                else
                    r = s;
                neuron_expected.push_back(r[16:0]);
            end
            default: ;
        endcase
    endtask

    function automatic void push_item(logic [1:0] cmd, int a, int w, int ti, int tv);
        neuron_item_t it;
        logic [16:0] av;
        logic [16:0] wv;
        av = a[16:0];
        wv = w[16:0];
        it.cmd  = cmd;
        it.data = {tv[8:0], ti[4:0], wv, av};
        pending_items.push_back(it);
    endfunction

    function automatic int full_val();
        return int'($urandom_range(0, 131070)) - 65535;
    endfunction

    function automatic int near_val(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Driver: bursts with random gaps, hold the item while stalled
    always @(posedge clk or negedge rst_n)
    begin
        neuron_item_t it;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tuser    <= '0;
            s_tdata    <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_neuron(s_tuser, s_tdata);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    it = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= it.cmd;
                    s_tdata  <= it.data;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off to back up the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_cnt   <= 0;
            hold_done  <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if (cycle_cnt % 64 == 0)
                stall_mode <= $urandom_range(0, 3);
            if (!hold_done && accepted_cnt >= 300)
            begin
                hold_done <= 1'b1;
                hold_cnt  <= 400;
                m_tready  <= 1'b0;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end
            else
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    // Monitor: compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin
        logic [16:0] exp_v;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (neuron_expected.size() == 0)
            begin
                $display("%0t: unexpected output, expected none, actual %h", $time, m_tdata[16:0]);
                err_cnt++;
            end
            else
            begin
                exp_v = neuron_expected.pop_front();
                if (m_tdata[16:0] !== exp_v)
                begin
                    $display("%0t: neuron_out mismatch, expected %h, actual %h",
                             $time, exp_v, m_tdata[16:0]);
                    err_cnt++;
                end
            end
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [16:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {15'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            qnm_pkg::REG_MODE:  mode_cfg  = value[1:0];
            qnm_pkg::REG_LOW:   low_cfg   = sext17(value);
            qnm_pkg::REG_HIGH:  high_cfg  = sext17(value);
            default:            scale_cfg = value[15:0];
        endcase
    endtask

    // Hold until every item is sent and answered, then let the pipe drain
    task automatic wait_idle();
        while (pending_items.size() > 0 || s_tvalid || neuron_expected.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [1:0] md, int lo, int hi, int sc);
        apb_write(qnm_pkg::REG_MODE, {15'd0, md});
        apb_write(qnm_pkg::REG_LOW, lo[16:0]);
        apb_write(qnm_pkg::REG_HIGH, hi[16:0]);
        apb_write(qnm_pkg::REG_SCALE, sc[16:0]);
    endtask

    task automatic random_items(int count);
        int n;
        int terms;
        bit wide;
        n = 0;
        while (n < count)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    push_item(qnm_pkg::CMD_TBL, full_val(), full_val(),
                              $urandom_range(0, 31), $urandom_range(0, 256));
                    n++;
                end
                1:
                begin
                    push_item(CMD_UNUSED, full_val(), full_val(), $urandom_range(0, 31),
                              $urandom_range(0, 511));
                end
                default:
                begin
                    terms = $urandom_range(0, 8);
                    wide  = ($urandom_range(0, 3) == 0);
                    repeat (terms)
                        push_item(qnm_pkg::CMD_MAC, wide ? full_val() : near_val(600),
                                  wide ? full_val() : near_val(600),
                                  $urandom_range(0, 31), $urandom_range(0, 511));
                    push_item(qnm_pkg::CMD_FIN, full_val(),
                              wide ? full_val() : near_val(2500),
                              $urandom_range(0, 31), $urandom_range(0, 511));
                    n += terms + 1;
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        err_cnt   = 0;
        accepted_cnt = 0;
        cycle_cnt = 0;
        acc_fx    = 0;
        mode_cfg  = qnm_pkg::MODE_RELU;
        low_cfg   = -2048;
        high_cfg  = 2048;
        scale_cfg = 496;
        foreach (sig_tbl[i])
            sig_tbl[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the whole table before any sigmoid lookup
        for (int i = 0; i < TSIZE; i++)
            push_item(qnm_pkg::CMD_TBL, 0, 0, i, (i * 8 > 256) ? 256 : i * 8);
        wait_idle();

        // Directed: field extremes, every command, unused command
        push_item(qnm_pkg::CMD_MAC, 65535, 65535, 0, 0);
        push_item(qnm_pkg::CMD_MAC, -65535, 65535, 31, 511);
        push_item(qnm_pkg::CMD_FIN, 0, 65535, 0, 0);
        push_item(qnm_pkg::CMD_MAC, -1, 255, 0, 0);
        push_item(qnm_pkg::CMD_MAC, 0, -65535, 0, 0);
        push_item(qnm_pkg::CMD_FIN, 0, -65535, 0, 0);
        push_item(CMD_UNUSED, 65535, -65535, 31, 511);
        push_item(qnm_pkg::CMD_FIN, 0, 0, 0, 0);
        push_item(qnm_pkg::CMD_MAC, 256, 256, 0, 0);
        push_item(qnm_pkg::CMD_FIN, -65535, -1, 0, 0);
        push_item(qnm_pkg::CMD_TBL, 0, 0, 31, 256);
        push_item(qnm_pkg::CMD_TBL, 0, 0, 0, 0);
        wait_idle();
        configure(qnm_pkg::MODE_SIG, -2048, 2048, 496);
        push_item(qnm_pkg::CMD_FIN, 0, -2049, 0, 0);
        push_item(qnm_pkg::CMD_FIN, 0, -2048, 0, 0);
        push_item(qnm_pkg::CMD_FIN, 0, 2047, 0, 0);
        push_item(qnm_pkg::CMD_FIN, 0, 2048, 0, 0);
        push_item(qnm_pkg::CMD_FIN, 0, 100, 0, 0);
        wait_idle();

        // Random phases through modes and bound settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: configure(qnm_pkg::MODE_RELU, -2048, 2048, 496);
                1: configure(qnm_pkg::MODE_SIG, -2048, 2048, 496);
                2: configure(MODE_NONE, -2048, 2048, 496);
                3: configure(MODE_SPARE, 0, 0, 0);
                4: configure(qnm_pkg::MODE_SIG, -65535, 65535, 65535);
                5: configure(qnm_pkg::MODE_SIG, -512, 512, 65535);
                6: configure(qnm_pkg::MODE_SIG, 1000, -1000, 300);
                7: configure(qnm_pkg::MODE_SIG, 0, 0, 0);
                default: configure(qnm_pkg::MODE_SIG, -4096, 4096, 1);
            endcase
            random_items(RANDOM_ITEMS);
            wait_idle();
        end

        if (err_cnt == 0 && neuron_expected.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
